@@ sv/mds_pkg.sv @@
// mds_pkg: shared types, constants and the popcount helper for the medoid descriptor select block
// no dependencies; used by every module in sv/
package mds_pkg;

	localparam int MAX_DESCRIPTORS_DEF = 32;
	localparam int WORD_W = 64;
	localparam int DESC_W = 4 * WORD_W;
	localparam int PART_W = 7;
	localparam int DIST_W = 9;

	// input transaction
	typedef struct packed {
		logic [WORD_W-1:0] desc_word0;
		logic [WORD_W-1:0] desc_word1;
		logic [WORD_W-1:0] desc_word2;
		logic [WORD_W-1:0] desc_word3;
		logic              last_desc;
	} desc_in_t;

	// result transaction
	typedef struct packed {
		logic [WORD_W-1:0] best_word0;
		logic [WORD_W-1:0] best_word1;
		logic [WORD_W-1:0] best_word2;
		logic [WORD_W-1:0] best_word3;
		logic [4:0]        best_index;
		logic [8:0]        best_median;
		logic [5:0]        set_count;
		logic              overflowed;
	} result_t;

	// status of the distance pipeline towards the sequencer
	typedef struct packed {
		logic              pipe_busy;
		logic              valid;
		logic [DIST_W-1:0] hdist;
	} dist_status_t;

	// ones in one byte
	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = 4'd0;
		for (int b = 0; b < 8; b++)
			n = n + {3'd0, v[b]};
		return n;
	endfunction

	// ones in one 64-bit word, as a sum of byte counts
	function automatic logic [PART_W-1:0] pop64(input logic [WORD_W-1:0] v);
		logic [PART_W-1:0] n;
		n = '0;
		for (int k = 0; k < 8; k++)
			n = n + {3'd0, pop8(v[8*k +: 8])};
		return n;
	endfunction

endpackage

@@ sv/mds_store.sv @@
// mds_store: descriptor memory, one 256-bit row per descriptor, registered read
// depends on mds_pkg
module mds_store #(
	parameter int DEPTH = mds_pkg::MAX_DESCRIPTORS_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [IDX_W-1:0]          waddr,
	input  logic [mds_pkg::DESC_W-1:0] wdata,
	input  logic [IDX_W-1:0]          raddr,
	output logic [mds_pkg::DESC_W-1:0] rdata_q
);

	logic [mds_pkg::DESC_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

@@ sv/mds_dist.sv @@
// mds_dist: shared two-stage hamming distance unit (xor, word popcounts, sum)
// depends on mds_pkg
module mds_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [mds_pkg::DESC_W-1:0] row,
	input  logic [mds_pkg::DESC_W-1:0] ref_row,
	output mds_pkg::dist_status_t      status
);

	logic [mds_pkg::PART_W-1:0] part_s1 [4];
	logic                       valid_s1;
	logic [mds_pkg::DIST_W-1:0] dist_s2;
	logic                       valid_s2;
	logic [mds_pkg::DESC_W-1:0] diff;

	assign diff = row ^ ref_row;

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: per-word popcounts
	always_ff @(posedge clk) begin
		for (int w = 0; w < 4; w++)
			part_s1[w] <= mds_pkg::pop64(diff[mds_pkg::WORD_W*w +: mds_pkg::WORD_W]);
	end

	// stage 2: sum of the four words
	always_ff @(posedge clk) begin
		dist_s2 <= mds_pkg::DIST_W'({2'd0, part_s1[0]}) + mds_pkg::DIST_W'({2'd0, part_s1[1]})
			+ mds_pkg::DIST_W'({2'd0, part_s1[2]}) + mds_pkg::DIST_W'({2'd0, part_s1[3]});
	end

	assign status.pipe_busy = in_valid | valid_s1 | valid_s2;
	assign status.valid     = valid_s2;
	assign status.hdist     = dist_s2;

endmodule

@@ sv/medoid_descriptor_select_unit.sv @@
// medoid_descriptor_select_unit: top level, descriptor loading and selection sequencer
// depends on mds_pkg, mds_store, mds_dist
//
// Usage: one descriptor per transaction on desc, taken when start is high and busy low.
// Descriptors are kept in load order up to MAX_DESCRIPTORS; further ones are dropped and
// the overflow flag is raised. The descriptor with last_desc set closes the set: busy
// rises and the block searches each row for the median distance by a bit-by-bit
// threshold search, one pass per bit of the 9-bit answer, each pass streaming all N
// rows through the shared distance unit, draining it and then evaluating the count.
// Each row also takes a row read, a reference load and a compare step, and the output
// takes a read and a load step before the result strobe.
// The result appears on result for exactly one cycle with done high; the receiver
// cannot hold it off. After it the set is empty and a new set may be loaded.
// Reset clears the count, the overflow flag and the sequencer; memory contents are
// not cleared and are never read before being written.
module medoid_descriptor_select_unit #(
	parameter int MAX_DESCRIPTORS = mds_pkg::MAX_DESCRIPTORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mds_pkg::desc_in_t desc,
	output logic              done,
	output mds_pkg::result_t  result
);

	localparam int IDX_W = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
	localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);
	localparam int DW    = mds_pkg::DIST_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ROW   = 9'b000000010,
		S_ROWL  = 9'b000000100,
		S_PASS  = 9'b000001000,
		S_DRAIN = 9'b000010000,
		S_EVAL  = 9'b000100000,
		S_CMP   = 9'b001000000,
		S_OUTR  = 9'b010000000,
		S_OUTL  = 9'b100000000
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	logic                       ovf_q;
	logic [IDX_W-1:0]           i_q;
	logic [IDX_W-1:0]           j_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [DW-1:0]              best_med_q;
	logic [DW-1:0]              acc_q;
	logic [3:0]                 bit_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       rdv_q;
	logic [mds_pkg::DESC_W-1:0] a_q;
	logic                       done_q;
	mds_pkg::result_t           res_q;

	logic                       accept;
	logic                       room;
	logic                       issue;
	logic [IDX_W-1:0]           raddr;
	logic [mds_pkg::DESC_W-1:0] rdata;
	logic [DW-1:0]              cand;
	logic [CNT_W-1:0]           rank;
	logic [CNT_W-1:0]           last_pos;
	mds_pkg::dist_status_t      dstat;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign room     = (count_q < CNT_W'(MAX_DESCRIPTORS));
	assign issue    = (state_q == S_PASS);
	assign cand     = acc_q | (DW'(1) << bit_q);
	assign last_pos = count_q - CNT_W'(1);
	assign rank     = last_pos >> 1;

	// read address selection
	always_comb begin
		case (state_q)
			S_PASS:  raddr = j_q;
			S_OUTR:  raddr = best_idx_q;
			default: raddr = i_q;
		endcase
	end

	mds_store #(.DEPTH(MAX_DESCRIPTORS), .IDX_W(IDX_W)) u_store (
		.clk     (clk),
		.we      (accept && room),
		.waddr   (count_q[IDX_W-1:0]),
		.wdata   ({desc.desc_word3, desc.desc_word2, desc.desc_word1, desc.desc_word0}),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	mds_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rdv_q),
		.row     (rdata),
		.ref_row (a_q),
		.status  (dstat)
	);

	// reference row register
	always_ff @(posedge clk) begin
		if (state_q == S_ROWL)
			a_q <= rdata;
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_OUTL) begin
			res_q.best_word0  <= rdata[0 +: mds_pkg::WORD_W];
			res_q.best_word1  <= rdata[mds_pkg::WORD_W +: mds_pkg::WORD_W];
			res_q.best_word2  <= rdata[2*mds_pkg::WORD_W +: mds_pkg::WORD_W];
			res_q.best_word3  <= rdata[3*mds_pkg::WORD_W +: mds_pkg::WORD_W];
			res_q.best_index  <= 5'(32'(best_idx_q));
			res_q.best_median <= best_med_q;
			res_q.set_count   <= 6'(32'(count_q));
			res_q.overflowed  <= ovf_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			best_idx_q <= '0;
			best_med_q <= '1;
			acc_q      <= '0;
			bit_q      <= '0;
			cnt_q      <= '0;
			rdv_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			rdv_q  <= issue;
			done_q <= 1'b0;
			// count hits below the threshold as distances leave the unit
			if (dstat.valid && (dstat.hdist < cand))
				cnt_q <= cnt_q + CNT_W'(1);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room)
							count_q <= count_q + CNT_W'(1);
						else
							ovf_q <= 1'b1;
						if (desc.last_desc) begin
							i_q        <= '0;
							best_idx_q <= '0;
							best_med_q <= '1;
							state_q    <= S_ROW;
						end
					end
				end
				S_ROW: state_q <= S_ROWL;
				S_ROWL: begin
					acc_q   <= '0;
					bit_q   <= 4'(DW - 1);
					j_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_PASS;
				end
				S_PASS: begin
					if (CNT_W'(j_q) == last_pos)
						state_q <= S_DRAIN;
					else
						j_q <= j_q + IDX_W'(1);
				end
				S_DRAIN: begin
					if (!dstat.pipe_busy)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					// answer is at least cand when fewer than rank+1 distances lie below it
					if (cnt_q <= rank)
						acc_q <= cand;
					cnt_q <= '0;
					j_q   <= '0;
					if (bit_q == 4'd0) begin
						state_q <= S_CMP;
					end else begin
						bit_q   <= bit_q - 4'd1;
						state_q <= S_PASS;
					end
				end
				S_CMP: begin
					if (acc_q < best_med_q) begin
						best_med_q <= acc_q;
						best_idx_q <= i_q;
					end
					if (CNT_W'(i_q) == last_pos) begin
						state_q <= S_OUTR;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_ROW;
					end
				end
				S_OUTR: state_q <= S_OUTL;
				S_OUTL: begin
					done_q  <= 1'b1;
					count_q <= '0;
					ovf_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result only follows the output load step
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_OUTL))
		else $error("result strobe without output load");

	// the set never grows past capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DESCRIPTORS))
		else $error("descriptor count beyond capacity");

	// a reported median is a real distance
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.best_median <= 9'd256))
		else $error("median out of range");

	// distance unit is idle when a threshold pass is evaluated
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> !dstat.pipe_busy)
		else $error("pass evaluated with distances in flight");

endmodule

@@ tb/tb_medoid_descriptor_select_unit.sv @@
// tb_medoid_descriptor_select_unit: self-checking testbench for the medoid descriptor select block
// depends on mds_pkg and medoid_descriptor_select_unit; predicts each selection and checks results
module tb_medoid_descriptor_select_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 32;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	mds_pkg::desc_in_t desc;
	logic              done;
	mds_pkg::result_t  result;

	// model of the set being loaded
	logic [mds_pkg::WORD_W-1:0] kept_words[CAPACITY][4];
	int                         kept_count;
	bit                         dropped_any;

	mds_pkg::result_t pending_selections[$];
	int               error_count;
	int               idle_pct;

	medoid_descriptor_select_unit #(.MAX_DESCRIPTORS(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.desc(desc), .done(done), .result(result)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [mds_pkg::WORD_W-1:0] got,
			input logic [mds_pkg::WORD_W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	function automatic int distance(input int a, input int b);
		int d;
		d = 0;
		for (int w = 0; w < 4; w++)
			d += $countones(kept_words[a][w] ^ kept_words[b][w]);
		return d;
	endfunction

	// store one accepted descriptor; on a closing one, predict the selection
	task automatic absorb_descriptor(input mds_pkg::desc_in_t d);
		mds_pkg::result_t sel;
		int               hist[257];
		int               rank;
		int               acc;
		int               med;
		int               best_med;
		int               best_idx;
		if (kept_count < CAPACITY) begin
			kept_words[kept_count][0] = d.desc_word0;
			kept_words[kept_count][1] = d.desc_word1;
			kept_words[kept_count][2] = d.desc_word2;
			kept_words[kept_count][3] = d.desc_word3;
			kept_count++;
		end else begin
			dropped_any = 1'b1;
		end
		if (!d.last_desc)
			return;
		rank = (kept_count - 1) / 2;
		best_med = 257;
		best_idx = 0;
		for (int i = 0; i < kept_count; i++) begin
			for (int k = 0; k <= 256; k++)
				hist[k] = 0;
			for (int j = 0; j < kept_count; j++)
				hist[distance(i, j)]++;
			acc = 0;
			med = 256;
			for (int k = 0; k <= 256; k++) begin
				acc += hist[k];
				if (acc > rank) begin
					med = k;
					break;
				end
			end
			// strict compare keeps the lowest index on a tie
			if (med < best_med) begin
				best_med = med;
				best_idx = i;
			end
		end
		sel.best_word0  = kept_words[best_idx][0];
		sel.best_word1  = kept_words[best_idx][1];
		sel.best_word2  = kept_words[best_idx][2];
		sel.best_word3  = kept_words[best_idx][3];
		sel.best_index  = best_idx[4:0];
		sel.best_median = best_med[8:0];
		sel.set_count   = kept_count[5:0];
		sel.overflowed  = dropped_any;
		pending_selections = {pending_selections, sel};
		kept_count  = 0;
		dropped_any = 1'b0;
	endtask

	// drive one transaction and wait for it to be taken
	task automatic send_descriptor(input mds_pkg::desc_in_t d);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		desc  <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		absorb_descriptor(d);
	endtask

	function automatic mds_pkg::desc_in_t make_desc(
			input logic [mds_pkg::WORD_W-1:0] w0, w1, w2, w3, input logic last);
		mds_pkg::desc_in_t d;
		d.desc_word0 = w0;
		d.desc_word1 = w1;
		d.desc_word2 = w2;
		d.desc_word3 = w3;
		d.last_desc  = last;
		return d;
	endfunction

	function automatic logic [mds_pkg::WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// up to three random bits of a base word overwritten with inverted random bits, so distances cluster and ties occur
	function automatic logic [mds_pkg::WORD_W-1:0] near_word(
			input logic [mds_pkg::WORD_W-1:0] base);
		logic [mds_pkg::WORD_W-1:0] v;
		v = base;
		repeat ($urandom_range(0, 3))
			v[$urandom_range(63)] = ~v[$urandom_range(63)];
		return v;
	endfunction

	task automatic hold_until_drained();
		start <= 1'b0;
		while (pending_selections.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// extremes, single sets, ties and a pair of opposites
	task automatic test_directed_sets();
		logic [mds_pkg::WORD_W-1:0] ones;
		ones = '1;
		send_descriptor(make_desc('0, '0, '0, '0, 1'b1));
		send_descriptor(make_desc(ones, ones, ones, ones, 1'b1));
		send_descriptor(make_desc('0, '0, '0, '0, 1'b0));
		send_descriptor(make_desc(ones, ones, ones, ones, 1'b1));
		send_descriptor(make_desc(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
			64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0));
		send_descriptor(make_desc(64'h5555555555555554, 64'haaaaaaaaaaaaaaaa,
			64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0));
		send_descriptor(make_desc(ones, '0, ones, '0, 1'b1));
		for (int i = 0; i < 4; i++)
			send_descriptor(make_desc(64'h1 << i, '0, '0, 64'h8000000000000000, i == 3));
	endtask

	// full store, then overflow including a dropped closing item
	task automatic test_capacity();
		for (int i = 0; i < CAPACITY; i++)
			send_descriptor(make_desc(rand_word(), rand_word(), rand_word(), rand_word(),
				i == CAPACITY - 1));
		for (int i = 0; i < CAPACITY + 2; i++)
			send_descriptor(make_desc(near_word('0), near_word('1), rand_word(),
				near_word('0), i == CAPACITY + 1));
	endtask

	task automatic test_random_sets(input int item_goal);
		int sent;
		int n;
		int flavour;
		logic [mds_pkg::WORD_W-1:0] b0, b1, b2, b3;
		sent = 0;
		while (sent < item_goal) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
			flavour = $urandom_range(2);
			b0 = rand_word(); b1 = rand_word(); b2 = rand_word(); b3 = rand_word();
			for (int i = 0; i < n; i++) begin
				if (flavour == 0)
					send_descriptor(make_desc(rand_word(), rand_word(), rand_word(),
						rand_word(), i == n - 1));
				else
					send_descriptor(make_desc(near_word(b0), near_word(b1), near_word(b2),
						near_word(b3), i == n - 1));
			end
			sent += n;
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		mds_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_selections.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_selections.pop_front();
				if (result.best_word0 !== want.best_word0)
					report_mismatch("best_word0", result.best_word0, want.best_word0);
				if (result.best_word1 !== want.best_word1)
					report_mismatch("best_word1", result.best_word1, want.best_word1);
				if (result.best_word2 !== want.best_word2)
					report_mismatch("best_word2", result.best_word2, want.best_word2);
				if (result.best_word3 !== want.best_word3)
					report_mismatch("best_word3", result.best_word3, want.best_word3);
				if (result.best_index !== want.best_index)
					report_mismatch("best_index", result.best_index, want.best_index);
				if (result.best_median !== want.best_median)
					report_mismatch("best_median", result.best_median, want.best_median);
				if (result.set_count !== want.set_count)
					report_mismatch("set_count", result.set_count, want.set_count);
				if (result.overflowed !== want.overflowed)
					report_mismatch("overflowed", result.overflowed, want.overflowed);
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		desc = '0;
		kept_count = 0;
		dropped_any = 1'b0;
		error_count = 0;
		idle_pct = 20;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_sets();
		hold_until_drained();
		test_capacity();
		idle_pct = 20;
		test_random_sets(400);
		hold_until_drained();
		idle_pct = 61;
		test_random_sets(400);
		idle_pct = 0;
		test_random_sets(380);

		start <= 1'b0;
		while (pending_selections.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#50ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
